### rtl/core/rpc_pkg.sv
// Shared constants, types and gain/arctangent tables for the rectangular/polar converter.
package rpc_pkg;

    localparam int ITERATIONS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int GUARD      = 16;
    localparam int ANG_FRAC   = 30;
    localparam int TAB_LEN    = 30;
    localparam int NITER      = (ITERATIONS < TAB_LEN) ? ITERATIONS : TAB_LEN;

    localparam int OPD_W    = 31;
    localparam int RES_W    = 32;
    localparam int S_DATA_W = ((2 * OPD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * RES_W + 7) / 8) * 8;

    // internal coordinate width: operand, guard bits and CORDIC growth
    localparam int XW    = OPD_W + GUARD + 3;
    localparam int ZW    = 34;
    localparam int ASH   = ANG_FRAC - FRAC_BITS;
    localparam int ZIN_W = OPD_W + ASH;
    localparam int IDX_W = $clog2(TAB_LEN);

    localparam int KW     = 30;
    localparam int KSPLIT = 15;
    localparam int PW     = XW + KSPLIT;

    localparam logic signed [ZW-1:0] PI_A      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_A = ZW'(64'sd1686629713);

    localparam logic KIND_R2P = 1'b0;
    localparam logic KIND_P2R = 1'b1;

    // arctan(2^-i), 30 fraction bits
    localparam logic [ANG_FRAC-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    // 1/prod(sqrt(1 + 2^-2i)), unsigned with 30 fraction bits, rounded to nearest
    function automatic logic [KW-1:0] gain_comp();
        logic [63:0] p;
        logic [63:0] pp;
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        p = 64'd1 << 60;
        for (int i = 0; i < NITER; i++) begin
            p = p + (p >> (2 * i));
        end
        pp    = p;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_v > pp) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_v != 64'd0) begin
                if (pp >= res + bit_v) begin
                    pp  = pp - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        num = (64'd1 << 60) + (res >> 1);
        rem = '0;
        q   = '0;
        // restoring long division
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[62:0], num[j]};
            if (rem >= res) begin
                rem  = rem - res;
                q[j] = 1'b1;
            end
        end
        return q[KW-1:0];
    endfunction

    localparam logic [KW-1:0]        GAIN_K = gain_comp();
    localparam logic [KW-KSPLIT-1:0] K_HI   = GAIN_K[KW-1:KSPLIT];
    localparam logic [KSPLIT-1:0]    K_LO   = GAIN_K[KSPLIT-1:0];

    typedef struct packed {
        logic                 kind;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } item_t;

endpackage

### rtl/core/rpc_pre.sv
// Input stage: scaling, left-half-plane fold and angle clamp/quadrant fold.
module rpc_pre (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic                             i_kind,
    input  logic signed [rpc_pkg::OPD_W-1:0] i_first,
    input  logic signed [rpc_pkg::OPD_W-1:0] i_second,
    output logic                             o_valid,
    output rpc_pkg::item_t                   o_item
);

    logic signed [rpc_pkg::XW-1:0]    xs;
    logic signed [rpc_pkg::XW-1:0]    ys;
    logic signed [rpc_pkg::ZIN_W-1:0] zb;
    logic signed [rpc_pkg::ZW-1:0]    zcl;
    logic                             valid_reg;
    rpc_pkg::item_t                   item_reg;
    rpc_pkg::item_t                   item_next;

    always_comb begin
        xs  = rpc_pkg::XW'(i_first) <<< rpc_pkg::GUARD;
        ys  = rpc_pkg::XW'(i_second) <<< rpc_pkg::GUARD;
        zb  = rpc_pkg::ZIN_W'(i_second) <<< rpc_pkg::ASH;
        if (zb > rpc_pkg::ZIN_W'(rpc_pkg::PI_A)) begin
            zcl = rpc_pkg::PI_A;
        end else if (zb < -rpc_pkg::ZIN_W'(rpc_pkg::PI_A)) begin
            zcl = -rpc_pkg::PI_A;
        end else begin
            zcl = rpc_pkg::ZW'(zb);
        end

        item_next.kind = i_kind;
        item_next.zero = 1'b0;
        item_next.x    = xs;
        item_next.y    = '0;
        item_next.z    = '0;
        if (i_kind == rpc_pkg::KIND_R2P) begin
            item_next.zero = (i_first == '0) && (i_second == '0);
            item_next.y    = ys;
            // left half plane: turn by pi first
            if (i_first[rpc_pkg::OPD_W-1]) begin
                item_next.x = -xs;
                item_next.y = -ys;
                item_next.z = i_second[rpc_pkg::OPD_W-1] ? -rpc_pkg::PI_A : rpc_pkg::PI_A;
            end
        end else begin
            // fold the angle into -pi/2..pi/2, negating the radius
            if (zcl > rpc_pkg::HALF_PI_A) begin
                item_next.z = zcl - rpc_pkg::PI_A;
                item_next.x = -xs;
            end else if (zcl < -rpc_pkg::HALF_PI_A) begin
                item_next.z = zcl + rpc_pkg::PI_A;
                item_next.x = -xs;
            end else begin
                item_next.z = zcl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_en) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            item_reg <= item_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_item  = item_reg;

endmodule

### rtl/core/rpc_gain.sv
// Three-stage CORDIC gain multiply on x, applied only to items of the selected kind.
module rpc_gain (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           i_en,
    input  logic           i_gain_kind,
    input  logic           i_valid,
    input  rpc_pkg::item_t i_item,
    output logic           o_valid,
    output rpc_pkg::item_t o_item
);

    localparam logic [rpc_pkg::PW-1:0] RND = rpc_pkg::PW'(2 ** (rpc_pkg::KSPLIT - 1));

    // stage 1: sign and magnitude
    logic                       s1_valid_reg;
    logic                       s1_neg_reg;
    logic                       s1_apply_reg;
    logic [rpc_pkg::XW-1:0]     s1_mag_reg;
    rpc_pkg::item_t             s1_item_reg;
    logic [rpc_pkg::XW-1:0]     mag_next;

    // stage 2: partial products against the split constant
    logic                       s2_valid_reg;
    logic                       s2_neg_reg;
    logic                       s2_apply_reg;
    logic [rpc_pkg::XW-1:0]     s2_mag_reg;
    logic [rpc_pkg::PW-1:0]     s2_hi_reg;
    logic [rpc_pkg::PW-1:0]     s2_lo_reg;
    rpc_pkg::item_t             s2_item_reg;
    logic [rpc_pkg::PW-1:0]     hi_next;
    logic [rpc_pkg::PW-1:0]     lo_next;

    // stage 3: combine, round, restore sign
    logic                       s3_valid_reg;
    rpc_pkg::item_t             s3_item_reg;
    rpc_pkg::item_t             s3_item_next;
    logic [rpc_pkg::PW:0]       sum;
    logic [rpc_pkg::XW-1:0]     res_mag;

    always_comb begin
        mag_next = i_item.x[rpc_pkg::XW-1] ? rpc_pkg::XW'(-i_item.x) : rpc_pkg::XW'(i_item.x);
        hi_next  = rpc_pkg::PW'(s1_mag_reg) * rpc_pkg::PW'(rpc_pkg::K_HI);
        lo_next  = rpc_pkg::PW'(s1_mag_reg) * rpc_pkg::PW'(rpc_pkg::K_LO);
        sum      = (rpc_pkg::PW+1)'(s2_hi_reg)
                 + (rpc_pkg::PW+1)'((s2_lo_reg + RND) >> rpc_pkg::KSPLIT)
                 + (rpc_pkg::PW+1)'(RND);
        res_mag  = s2_apply_reg ? rpc_pkg::XW'(sum >> rpc_pkg::KSPLIT) : s2_mag_reg;
        s3_item_next   = s2_item_reg;
        s3_item_next.x = s2_neg_reg ? -$signed(res_mag) : $signed(res_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (i_en) begin
            s1_valid_reg <= i_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            s1_neg_reg   <= i_item.x[rpc_pkg::XW-1];
            s1_apply_reg <= (i_item.kind == i_gain_kind);
            s1_mag_reg   <= mag_next;
            s1_item_reg  <= i_item;
            s2_neg_reg   <= s1_neg_reg;
            s2_apply_reg <= s1_apply_reg;
            s2_mag_reg   <= s1_mag_reg;
            s2_hi_reg    <= hi_next;
            s2_lo_reg    <= lo_next;
            s2_item_reg  <= s1_item_reg;
            s3_item_reg  <= s3_item_next;
        end
    end

    assign o_valid = s3_valid_reg;
    assign o_item  = s3_item_reg;

endmodule

### rtl/core/rpc_cordic_stage.sv
// One registered CORDIC micro-rotation, vectoring or rotating by item kind.
module rpc_cordic_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      i_en,
    input  logic [rpc_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_valid,
    input  rpc_pkg::item_t            i_item,
    output logic                      o_valid,
    output rpc_pkg::item_t            o_item
);

    logic                          dir_sub;
    logic signed [rpc_pkg::XW-1:0] xs;
    logic signed [rpc_pkg::XW-1:0] ys;
    logic signed [rpc_pkg::ZW-1:0] at;
    logic                          valid_reg;
    rpc_pkg::item_t                item_reg;
    rpc_pkg::item_t                item_next;

    always_comb begin
        // rotating: follow sign of z; vectoring: drive y towards zero
        dir_sub = (i_item.kind == rpc_pkg::KIND_P2R) ? ~i_item.z[rpc_pkg::ZW-1]
                                                     : i_item.y[rpc_pkg::XW-1];
        xs = i_item.x >>> i_idx;
        ys = i_item.y >>> i_idx;
        at = $signed(rpc_pkg::ZW'(rpc_pkg::ATAN_TAB[i_idx]));
        item_next = i_item;
        if (dir_sub) begin
            item_next.x = i_item.x - ys;
            item_next.y = i_item.y + xs;
            item_next.z = i_item.z - at;
        end else begin
            item_next.x = i_item.x + ys;
            item_next.y = i_item.y - xs;
            item_next.z = i_item.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (i_en) begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            item_reg <= item_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_item  = item_reg;

endmodule

### rtl/core/rpc_out.sv
// Result rounding/saturation with output register and skid buffer.
module rpc_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            i_valid,
    input  rpc_pkg::item_t                  i_item,
    output logic                            o_en,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpc_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int TW = rpc_pkg::XW + 1;
    localparam logic signed [TW-1:0] CRND = TW'(2 ** (rpc_pkg::GUARD - 1));
    localparam logic signed [TW-1:0] SMAX = TW'((64'sd1 <<< (rpc_pkg::RES_W - 1)) - 64'sd1);
    localparam logic signed [TW-1:0] SMIN = TW'(-(64'sd1 <<< (rpc_pkg::RES_W - 1)));
    localparam logic signed [rpc_pkg::ZW-1:0] ARND = rpc_pkg::ZW'(2 ** (rpc_pkg::ASH - 1));

    logic signed [TW-1:0]             xt;
    logic signed [TW-1:0]             yt;
    logic signed [rpc_pkg::RES_W-1:0] xc;
    logic signed [rpc_pkg::RES_W-1:0] yc;
    logic signed [rpc_pkg::ZW-1:0]    zc;
    logic signed [rpc_pkg::ZW-1:0]    zt;
    logic signed [rpc_pkg::RES_W-1:0] ang;
    logic [rpc_pkg::RES_W-1:0]        first_res;
    logic [rpc_pkg::RES_W-1:0]        second_res;
    logic [rpc_pkg::M_DATA_W-1:0]     data_next;
    logic                             arrive;

    logic                             out_valid_reg;
    logic                             skid_valid_reg;
    logic [rpc_pkg::M_DATA_W-1:0]     out_data_reg;
    logic [rpc_pkg::M_DATA_W-1:0]     skid_data_reg;

    always_comb begin
        xt = (TW'(i_item.x) + CRND) >>> rpc_pkg::GUARD;
        yt = (TW'(i_item.y) + CRND) >>> rpc_pkg::GUARD;
        if (xt > SMAX) begin
            xc = rpc_pkg::RES_W'(SMAX);
        end else if (xt < SMIN) begin
            xc = rpc_pkg::RES_W'(SMIN);
        end else begin
            xc = rpc_pkg::RES_W'(xt);
        end
        if (yt > SMAX) begin
            yc = rpc_pkg::RES_W'(SMAX);
        end else if (yt < SMIN) begin
            yc = rpc_pkg::RES_W'(SMIN);
        end else begin
            yc = rpc_pkg::RES_W'(yt);
        end

        if (i_item.z > rpc_pkg::PI_A) begin
            zc = rpc_pkg::PI_A;
        end else if (i_item.z < -rpc_pkg::PI_A) begin
            zc = -rpc_pkg::PI_A;
        end else begin
            zc = i_item.z;
        end
        zt  = (zc + ARND) >>> rpc_pkg::ASH;
        ang = rpc_pkg::RES_W'(zt);

        if (i_item.kind == rpc_pkg::KIND_R2P) begin
            // origin gives zero radius and zero angle
            first_res  = i_item.zero ? '0 : xc;
            second_res = i_item.zero ? '0 : ang;
        end else begin
            first_res  = xc;
            second_res = yc;
        end
        data_next = rpc_pkg::M_DATA_W'({second_res, first_res});
    end

    assign o_en   = ~skid_valid_reg;
    assign arrive = i_valid & ~skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= arrive;
            end
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : data_next;
        end
        if (arrive && out_valid_reg && !m_tready) begin
            skid_data_reg <= data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/core/rect_polar_converter.sv
// Top level: rectangular <-> polar converter built as a fully unrolled CORDIC pipeline.
//
// Input stream (s_*): s_tuser selects the conversion (0: (x, y) to (radius, angle),
// 1: (radius, angle) to (x, y)); s_tdata carries the two signed 31-bit operands.
// Coordinates and radius are Q14.16, angles Q2.16 radians (inputs clamped to +-pi).
// Output stream (m_*): m_tdata carries the two signed 32-bit results.
// Every transfer in gives exactly one transfer out, in order.
// Stages: each item passes through one input stage, three gain-multiply stages, one
// stage per CORDIC iteration (16), three more gain stages for the vectoring path,
// and the output register.
// Throughput: one item per cycle while s_tready is high; every stage is registered,
// so a new item may enter on each clock unless the pipeline is frozen.
// Stalls: the output register is backed by a one-entry skid buffer. When the receiver
// holds m_tready low, one further result lands in the skid buffer, then the whole
// pipeline freezes and s_tready drops until the skid buffer drains. Nothing is lost
// or repeated. s_tready depends only on registered state.
// Reset: aresetn (synchronous, active low) empties all stages; nothing else to clear.
module rect_polar_converter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rpc_pkg::S_DATA_W-1:0]    s_tdata,  // [30:0] first_operand, [61:31] second_operand
    input  logic                            s_tuser,  // [0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpc_pkg::M_DATA_W-1:0]    m_tdata   // [31:0] first_result, [63:32] second_result
);

    logic           en;
    logic           pre_valid;
    rpc_pkg::item_t pre_item;
    logic           ga_valid;
    rpc_pkg::item_t ga_item;
    logic           gb_valid;
    rpc_pkg::item_t gb_item;
    logic           cv [0:rpc_pkg::NITER];
    rpc_pkg::item_t ci [0:rpc_pkg::NITER];

    assign s_tready = en;

    rpc_pre u_pre (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .i_en     (en),
        .i_valid  (s_tvalid),
        .i_kind   (s_tuser),
        .i_first  ($signed(s_tdata[rpc_pkg::OPD_W-1:0])),
        .i_second ($signed(s_tdata[2*rpc_pkg::OPD_W-1:rpc_pkg::OPD_W])),
        .o_valid  (pre_valid),
        .o_item   (pre_item)
    );

    // radius pre-scaled by the gain before rotation
    rpc_gain u_gain_rot (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .i_en        (en),
        .i_gain_kind (rpc_pkg::KIND_P2R),
        .i_valid     (pre_valid),
        .i_item      (pre_item),
        .o_valid     (ga_valid),
        .o_item      (ga_item)
    );

    assign cv[0] = ga_valid;
    assign ci[0] = ga_item;

    for (genvar g = 0; g < rpc_pkg::NITER; g++) begin : g_iter
        rpc_cordic_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .i_en    (en),
            .i_idx   (rpc_pkg::IDX_W'(g)),
            .i_valid (cv[g]),
            .i_item  (ci[g]),
            .o_valid (cv[g+1]),
            .o_item  (ci[g+1])
        );
    end

    // radius from vectoring scaled by the gain afterwards
    rpc_gain u_gain_vec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .i_en        (en),
        .i_gain_kind (rpc_pkg::KIND_R2P),
        .i_valid     (cv[rpc_pkg::NITER]),
        .i_item      (ci[rpc_pkg::NITER]),
        .o_valid     (gb_valid),
        .o_item      (gb_item)
    );

    rpc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .i_valid  (gb_valid),
        .i_item   (gb_item),
        .o_en     (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the rectangular/polar CORDIC converter stream.
`timescale 1ns / 100ps

module tb;

    localparam logic R2P = rpc_pkg::KIND_R2P;
    localparam logic P2R = rpc_pkg::KIND_P2R;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 150;
    localparam int N_ROT        = 16;
    localparam int N_DIRECTED   = 24;

    localparam int OPD_MAX   = 1073741823;
    localparam int OPD_MIN   = -1073741824;
    localparam int ONE_Q     = 65536;
    localparam int PI_Q      = 205887;
    localparam int HALF_PI_Q = 102944;

    // angles held internally with 30 fraction bits
    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] first;
        logic signed [31:0] second;
    } conv_result_t;

    typedef struct packed {
        logic               kind;
        logic signed [30:0] a;
        logic signed [30:0] b;
        logic               known;
        logic signed [31:0] r0;
        logic signed [31:0] r1;
    } dir_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rpc_pkg::S_DATA_W-1:0]   s_tdata;  // [30:0] first_operand, [61:31] second_operand
    logic                           s_tuser;  // [0] kind
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rpc_pkg::M_DATA_W-1:0]   m_tdata;  // [31:0] first_result, [63:32] second_result

    conv_result_t pending_results[$];
    longint unsigned gain_k;
    int err_cnt;
    int checked_cnt;
    int sent_cnt;
    int r2p_cnt;
    int p2r_cnt;
    int in_stall_cycles;
    int cycles;
    bit tight;

    // origin and zero radius are the only rows with results typed in
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{R2P, 0, 0, 1'b1, 0, 0},
        '{P2R, 0, 0, 1'b1, 0, 0},
        '{P2R, 0, OPD_MAX, 1'b1, 0, 0},
        '{R2P, OPD_MAX, 0, 1'b0, 0, 0},
        '{R2P, OPD_MIN, 0, 1'b0, 0, 0},
        '{R2P, 0, OPD_MAX, 1'b0, 0, 0},
        '{R2P, 0, OPD_MIN, 1'b0, 0, 0},
        '{R2P, OPD_MAX, OPD_MAX, 1'b0, 0, 0},
        '{R2P, OPD_MIN, OPD_MIN, 1'b0, 0, 0},
        '{R2P, OPD_MIN, OPD_MAX, 1'b0, 0, 0},
        '{R2P, OPD_MAX, OPD_MIN, 1'b0, 0, 0},
        '{R2P, -1, 0, 1'b0, 0, 0},
        '{R2P, -ONE_Q, -1, 1'b0, 0, 0},
        '{R2P, 1, 1, 1'b0, 0, 0},
        '{P2R, ONE_Q, 0, 1'b0, 0, 0},
        '{P2R, ONE_Q, PI_Q, 1'b0, 0, 0},
        '{P2R, ONE_Q, -PI_Q, 1'b0, 0, 0},
        '{P2R, OPD_MAX, HALF_PI_Q, 1'b0, 0, 0},
        '{P2R, OPD_MAX, OPD_MAX, 1'b0, 0, 0},
        '{P2R, OPD_MAX, OPD_MIN, 1'b0, 0, 0},
        '{P2R, OPD_MIN, 0, 1'b0, 0, 0},
        '{P2R, OPD_MIN, -HALF_PI_Q, 1'b0, 0, 0},
        '{P2R, -ONE_Q, 1, 1'b0, 0, 0},
        '{P2R, OPD_MAX, PI_Q + 1, 1'b0, 0, 0}
    };

    rect_polar_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic longint atan_step(int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            default: return 64'sd1 <<< (30 - i);
        endcase
    endfunction

    // 1/prod(sqrt(1 + 2^-2i)) as a 30-bit fraction, rounded to nearest
    function automatic longint unsigned gain_factor();
        longint unsigned p;
        longint unsigned res;
        longint unsigned bitv;
        int i;
        p = 64'd1 << 60;
        for (i = 0; i < N_ROT; i++) begin
            p = p + (p >> (2 * i));
        end
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > p) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (p >= res + bitv) begin
                p   = p - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return ((64'd1 << 60) + (res >> 1)) / res;
    endfunction

    // magnitude times K, split 15/15 with round-half-up at each step
    function automatic longint scale_by_gain(longint v);
        longint unsigned m;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        m  = (v < 0) ? -v : v;
        hi = gain_k >> 15;
        lo = gain_k & 64'h7fff;
        r  = (m * hi + ((m * lo + 64'h4000) >> 15) + 64'h4000) >> 15;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] round_coord(longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > COORD_MAX) r = COORD_MAX;
        if (r < COORD_MIN) r = COORD_MIN;
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] round_angle(longint z);
        longint r;
        if (z > ANG_PI) z = ANG_PI;
        if (z < -ANG_PI) z = -ANG_PI;
        r = (z + 64'sd8192) >>> 14;
        return r[31:0];
    endfunction

    function automatic conv_result_t cordic_convert(logic kind, logic signed [30:0] a,
                                                    logic signed [30:0] b);
        longint x;
        longint y;
        longint z;
        longint nx;
        conv_result_t r;
        int i;
        if (kind == R2P) begin
            if (a == 0 && b == 0) begin
                r.first  = 0;
                r.second = 0;
                return r;
            end
            x = longint'(a) * 65536;
            y = longint'(b) * 65536;
            z = 0;
            // left half plane: fold by pi first
            if (x < 0) begin
                z = (y >= 0) ? ANG_PI : -ANG_PI;
                x = -x;
                y = -y;
            end
            for (i = 0; i < N_ROT; i++) begin
                if (y < 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_step(i);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_step(i);
                end
                x = nx;
            end
            r.first  = round_coord(scale_by_gain(x));
            r.second = round_angle(z);
        end else begin
            z = longint'(b) * 16384;
            if (z > ANG_PI) z = ANG_PI;
            if (z < -ANG_PI) z = -ANG_PI;
            x = scale_by_gain(longint'(a) * 65536);
            y = 0;
            if (z > ANG_HALF_PI) begin
                z = z - ANG_PI;
                x = -x;
            end else if (z < -ANG_HALF_PI) begin
                z = z + ANG_PI;
                x = -x;
            end
            for (i = 0; i < N_ROT; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_step(i);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_step(i);
                end
                x = nx;
            end
            r.first  = round_coord(x);
            r.second = round_coord(y);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 80) return $urandom_range(1, 2);
        if (sel < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [30:0] rand_operand();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 31'($urandom());
        if (sel < 70) return 31'(int'($urandom_range(0, 2097152)) - 1048576);
        if (sel < 85) return 31'(int'($urandom_range(0, 600)) - 300);
        if (sel < 95) begin
            case ($urandom_range(0, 5))
                0: v = OPD_MAX;
                1: v = OPD_MIN;
                2: v = 0;
                3: v = 1;
                4: v = -1;
                default: v = OPD_MAX - 1;
            endcase
            return 31'(v);
        end
        v = 1 << $urandom_range(0, 29);
        return 31'($urandom_range(0, 1) ? -v : v);
    endfunction

    function automatic logic signed [30:0] rand_angle();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 31'(int'($urandom_range(0, 2 * PI_Q)) - PI_Q);
        if (sel < 80) begin
            case ($urandom_range(0, 4))
                0: v = PI_Q;
                1: v = -PI_Q;
                2: v = HALF_PI_Q;
                3: v = -HALF_PI_Q;
                default: v = 0;
            endcase
            return 31'(v);
        end
        if (sel < 90) begin
            v = PI_Q + 1 + int'($urandom_range(0, 1000000));
            return 31'($urandom_range(0, 1) ? -v : v);
        end
        return rand_operand();
    endfunction

    // offer one item, hold it until the transfer, then record what must come back
    task automatic send_item(input logic kind, input logic signed [30:0] a,
                             input logic signed [30:0] b, input conv_result_t want);
        int gap;
        gap = tight ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, b, a};
        @(posedge aclk);
        while (!s_tready) begin
            in_stall_cycles++;
            @(posedge aclk);
        end
        pending_results.push_back(want);
        sent_cnt++;
        if (kind == R2P) r2p_cnt++;
        else p2r_cnt++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: ready runs and stalls, plus one long hold to back the pipe up
    initial begin : sink
        int run;
        int stall;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sent_cnt >= N_DIRECTED + 40) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if ($signed(m_tdata[31:0]) !== want.first) begin
                    $error("first_result: expected %0d, got %0d",
                           want.first, $signed(m_tdata[31:0]));
                    err_cnt++;
                end
                if ($signed(m_tdata[63:32]) !== want.second) begin
                    $error("second_result: expected %0d, got %0d",
                           want.second, $signed(m_tdata[63:32]));
                    err_cnt++;
                end
                checked_cnt++;
            end
        end
    end

    initial begin : stimulus
        conv_result_t want;
        logic kind;
        logic signed [30:0] a;
        logic signed [30:0] b;
        int i;
        err_cnt         = 0;
        checked_cnt     = 0;
        sent_cnt        = 0;
        r2p_cnt         = 0;
        p2r_cnt         = 0;
        in_stall_cycles = 0;
        tight           = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= R2P;
        s_tdata  <= '0;
        gain_k = gain_factor();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].known) begin
                want.first  = directed_rows[i].r0;
                want.second = directed_rows[i].r1;
            end else begin
                want = cordic_convert(directed_rows[i].kind, directed_rows[i].a,
                                      directed_rows[i].b);
            end
            send_item(directed_rows[i].kind, directed_rows[i].a, directed_rows[i].b, want);
        end

        // opening burst without gaps coincides with the receiver's long hold
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            tight = (i < 200) || ((i / 250) % 4 == 2);
            kind  = $urandom_range(0, 1) ? P2R : R2P;
            a     = rand_operand();
            b     = (kind == P2R) ? rand_angle() : rand_operand();
            send_item(kind, a, b, cordic_convert(kind, a, b));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d conversions checked: %0d rect->polar, %0d polar->rect",
                 checked_cnt, r2p_cnt, p2r_cnt);
        $display("input held off for %0d cycles, %0d cycles in total",
                 in_stall_cycles, cycles);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
